### design/nonlinear_posterize_quantizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the posterization quantizer
// Shared helpers that wrap a clocked property with reset gating.
// ----------------------------------------------------------------------------
`ifndef NONLINEAR_POSTERIZE_QUANTIZER_CORE_DEFINES_SVH
`define NONLINEAR_POSTERIZE_QUANTIZER_CORE_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define NPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define NPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/npq_pkg.sv
// ----------------------------------------------------------------------------
// npq_pkg
// Types, codes and arithmetic helpers shared by the quantizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package npq_pkg;

    // Fraction bits of the pixel format.
    localparam int FRAC_BITS = 8;
    localparam logic [32:0] ONE_Q = 33'd1 << FRAC_BITS;
    localparam logic [21:0] LOG_BASE = 22'(FRAC_BITS) << 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] MODE_UNIFORM = 3'd0;
    localparam logic [2:0] MODE_LOG     = 3'd1;
    localparam logic [2:0] MODE_EXP     = 3'd2;
    localparam logic [2:0] MODE_SQRT    = 3'd3;
    localparam logic [2:0] MODE_POW     = 3'd4;

    localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] REG_CURVE_MODE  = 2'd1;
    localparam logic [1:0] REG_RANGE_LOW   = 2'd2;
    localparam logic [1:0] REG_RANGE_HIGH  = 2'd3;

    localparam logic [7:0]  LEVEL_COUNT_RST = 8'd16;
    localparam logic [31:0] RANGE_HIGH_RST  = 32'd65280;

    // Classification of a pixel made by the front end.
    localparam logic [1:0] KIND_CURVE     = 2'd0;
    localparam logic [1:0] KIND_ZERO      = 2'd1;
    localparam logic [1:0] KIND_TOP       = 2'd2;
    localparam logic [1:0] KIND_RANGE_ERR = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] d;
    } item_t;

    typedef struct packed {
        logic        busy;
        logic        rerr;
        logic [7:0]  n;
        logic [2:0]  mode;
        logic [31:0] lo;
        logic [31:0] w;
        logic [63:0] wsq;
        logic [15:0] nsq;
        logic [19:0] ln;
        logic [21:0] lb;
    } cfg_t;

    typedef logic [255:0][19:0] log_tab_t;

    // Index of the highest set bit.
    function automatic logic [5:0] lead_one(input logic [32:0] v);
        logic [5:0] e;
        e = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                e = 6'(i);
            end
        end
        return e;
    endfunction

    // Mantissa in Q30, top bit at position 30.
    function automatic logic [30:0] normalize(input logic [32:0] v, input logic [5:0] e);
        logic [32:0] t;
        t = (e >= 6'd30) ? (v >> (e - 6'd30)) : (v << (6'd30 - e));
        return t[30:0];
    endfunction

    // One squaring step of the logarithm: bit 31 is the fraction bit, 30:0 the mantissa.
    function automatic logic [31:0] log_step(input logic [30:0] m);
        logic [61:0] p;
        logic [31:0] q;
        p = {31'b0, m} * {31'b0, m};
        q = p[61:30];
        return q[31] ? {1'b1, q[31:1]} : {1'b0, q[30:0]};
    endfunction

    // Entry k holds the Q16 base-2 logarithm of k + 1.
    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [32:0] v;
        logic [5:0]  e;
        logic [30:0] m;
        logic [31:0] st;
        logic [15:0] frac;
        for (int k = 0; k < 256; k++) begin
            v = 33'(k + 1);
            e = lead_one(v);
            m = normalize(v, e);
            frac = '0;
            for (int j = 0; j < 16; j++) begin
                st = log_step(m);
                m = st[30:0];
                frac[15 - j] = st[31];
            end
            tab[k] = {e[3:0], frac};
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

### design/npq_cfg.sv
// ----------------------------------------------------------------------------
// npq_cfg
// Configuration registers and the derived constants of the current range.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    output npq_pkg::cfg_t     cfg
);

    localparam logic [4:0] STEP_LAST = 5'd20;

    logic        wr;
    logic [7:0]  n_reg;
    logic [2:0]  mode_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic        busy_reg;
    logic [4:0]  step_reg;

    logic [31:0] w_reg;
    logic        rerr_reg;
    logic [63:0] wsq_reg;
    logic [15:0] nsq_reg;
    logic [19:0] ln_reg;
    logic [21:0] lb_reg;
    logic [32:0] v_reg;
    logic [5:0]  e_reg;
    logic [30:0] m_reg;
    logic [15:0] frac_reg;
    logic [31:0] st;
    logic [4:0]  fi;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;
    assign st = npq_pkg::log_step(m_reg);
    assign fi = 5'd19 - step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= npq_pkg::LEVEL_COUNT_RST;
            mode_reg <= npq_pkg::MODE_UNIFORM;
            lo_reg   <= '0;
            hi_reg   <= npq_pkg::RANGE_HIGH_RST;
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (wr)
        begin
            case (cfg_index)
                npq_pkg::REG_LEVEL_COUNT: n_reg    <= cfg_data[7:0];
                npq_pkg::REG_CURVE_MODE:  mode_reg <= cfg_data[2:0];
                npq_pkg::REG_RANGE_LOW:   lo_reg   <= cfg_data;
                npq_pkg::REG_RANGE_HIGH:  hi_reg   <= cfg_data;
                default:                  n_reg    <= n_reg;
            endcase
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Derived values are rebuilt step by step after every write.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !wr)
        begin
            if (step_reg == 5'd0)
            begin
                w_reg    <= hi_reg - lo_reg;
                rerr_reg <= $signed(hi_reg) <= $signed(lo_reg);
                nsq_reg  <= {8'b0, n_reg} * {8'b0, n_reg};
                ln_reg   <= npq_pkg::LOG_TAB[n_reg];
            end
            else if (step_reg == 5'd1)
            begin
                v_reg   <= {1'b0, w_reg} + npq_pkg::ONE_Q;
                wsq_reg <= {32'b0, w_reg} * {32'b0, w_reg};
            end
            else if (step_reg == 5'd2)
            begin
                e_reg <= npq_pkg::lead_one(v_reg);
            end
            else if (step_reg == 5'd3)
            begin
                m_reg    <= npq_pkg::normalize(v_reg, e_reg);
                frac_reg <= '0;
            end
            else if (step_reg inside {[5'd4:5'd19]})
            begin
                m_reg            <= st[30:0];
                frac_reg[fi[3:0]] <= st[31];
            end
            else
            begin
                lb_reg <= {e_reg, frac_reg} - npq_pkg::LOG_BASE;
            end
        end
    end

    always_comb
    begin
        cfg.busy = busy_reg;
        cfg.rerr = rerr_reg;
        cfg.n    = n_reg;
        cfg.mode = (mode_reg inside {npq_pkg::MODE_LOG, npq_pkg::MODE_EXP,
                                     npq_pkg::MODE_SQRT, npq_pkg::MODE_POW})
                   ? mode_reg : npq_pkg::MODE_UNIFORM;
        cfg.lo   = lo_reg;
        cfg.w    = w_reg;
        cfg.wsq  = wsq_reg;
        cfg.nsq  = nsq_reg;
        cfg.ln   = ln_reg;
        cfg.lb   = lb_reg;
    end

endmodule

`default_nettype wire

### design/npq_front.sv
// ----------------------------------------------------------------------------
// npq_front
// Accepts pixels, offsets them by the range minimum and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   in_pixel,
    input  npq_pkg::cfg_t      cfg,
    output logic               push_valid,
    input  wire logic          push_ready,
    output npq_pkg::item_t     push_item
);

    logic           hold_valid_reg;
    npq_pkg::item_t item_reg;
    npq_pkg::item_t item_next;
    logic signed [32:0] sd;

    assign in_ready = !cfg.busy && (!hold_valid_reg || push_ready);
    assign sd = $signed({in_pixel[31], in_pixel}) - $signed({cfg.lo[31], cfg.lo});

    always_comb
    begin
        item_next.d = sd[31:0];
        if (cfg.rerr)
        begin
            item_next.kind = npq_pkg::KIND_RANGE_ERR;
        end
        else if (sd <= 33'sd0)
        begin
            item_next.kind = npq_pkg::KIND_ZERO;
        end
        else if (sd >= $signed({1'b0, cfg.w}))
        begin
            item_next.kind = npq_pkg::KIND_TOP;
        end
        else
        begin
            item_next.kind = npq_pkg::KIND_CURVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = item_reg;

endmodule

`default_nettype wire

### design/npq_fifo.sv
// ----------------------------------------------------------------------------
// npq_fifo
// Short queue of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  npq_pkg::item_t     push_item,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output npq_pkg::item_t     pop_item
);

    localparam int PW = $clog2(npq_pkg::QUEUE_DEPTH);

    npq_pkg::item_t     mem_reg [npq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != (PW+1)'(npq_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### design/npq_back.sv
// ----------------------------------------------------------------------------
// npq_back
// Pipeline that evaluates the curve: logarithm, operand forming and an
// eight-stage search for the level, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  npq_pkg::item_t     pop_item,
    input  npq_pkg::cfg_t      cfg,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_level,
    output logic               out_rerr
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] d;
        logic [63:0] dd;
        logic [5:0]  e;
        logic [30:0] m;
        logic [15:0] frac;
    } lg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        zden;
        logic [7:0]  k;
        logic [73:0] p;
        logic [73:0] q;
        logic [73:0] x;
        logic [63:0] y;
    } srch_t;

    logic adv;

    // Stage A: offset by one unit and find the top bit.
    logic        a_valid_reg;
    logic [1:0]  a_kind_reg;
    logic [31:0] a_d_reg;
    logic [32:0] a_v_reg;
    logic [5:0]  a_e_reg;
    logic [32:0] a_v_next;

    // Stage B: normalise the mantissa and square the offset.
    logic b_valid_reg;
    lg_t  b_reg;
    lg_t  b_next;

    logic  lg_valid_reg [16];
    lg_t   lg_reg [16];
    lg_t   lg_next [16];

    logic  f_valid_reg;
    srch_t f_reg;
    srch_t f_next;

    logic  srch_valid_reg [8];
    srch_t srch_reg [8];
    srch_t srch_next [8];

    logic       out_valid_reg;
    logic [7:0] out_level_reg;
    logic       out_rerr_reg;
    logic [7:0] level_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign a_v_next  = {1'b0, pop_item.d} + npq_pkg::ONE_Q;

    always_comb
    begin
        b_next.kind = a_kind_reg;
        b_next.d    = a_d_reg;
        b_next.dd   = {32'b0, a_d_reg} * {32'b0, a_d_reg};
        b_next.e    = a_e_reg;
        b_next.m    = npq_pkg::normalize(a_v_reg, a_e_reg);
        b_next.frac = '0;
    end

    genvar j;
    for (j = 0; j < 16; j++) begin : g_log
        lg_t         src;
        logic [31:0] st;
        if (j == 0) begin : g_first
            assign src = b_reg;
        end
        else begin : g_rest
            assign src = lg_reg[j-1];
        end
        assign st = npq_pkg::log_step(src.m);
        always_comb
        begin
            lg_next[j] = src;
            lg_next[j].m = st[30:0];
            lg_next[j].frac[15-j] = st[31];
        end
    end

    // Operand forming: the level is the largest k with k*y <= x (or the
    // curve-specific equivalent tested in the search stages).
    logic [21:0] lg_a;
    logic [39:0] p_uni;
    logic [71:0] p_sqrt;
    logic [29:0] p_exp;
    logic [47:0] p_pow;
    logic [51:0] p_log;

    assign lg_a   = {lg_reg[15].e, lg_reg[15].frac} - npq_pkg::LOG_BASE;
    assign p_uni  = {32'b0, cfg.n} * {8'b0, lg_reg[15].d};
    assign p_sqrt = {64'b0, cfg.n} * {8'b0, lg_reg[15].dd};
    assign p_exp  = {22'b0, cfg.n} * {8'b0, lg_a};
    assign p_pow  = {32'b0, cfg.nsq} * {16'b0, lg_reg[15].d};
    assign p_log  = {20'b0, lg_reg[15].d} * {32'b0, cfg.ln};

    always_comb
    begin
        f_next.kind = lg_reg[15].kind;
        f_next.zden = 1'b0;
        f_next.k    = '0;
        f_next.p    = '0;
        f_next.q    = '0;
        case (cfg.mode)
            npq_pkg::MODE_LOG:
            begin
                f_next.x = {22'b0, p_log};
                f_next.y = {32'b0, cfg.w};
            end
            npq_pkg::MODE_EXP:
            begin
                f_next.x    = {44'b0, p_exp};
                f_next.y    = {42'b0, cfg.lb};
                f_next.zden = cfg.lb == '0;
            end
            npq_pkg::MODE_SQRT:
            begin
                f_next.x = {2'b0, p_sqrt};
                f_next.y = cfg.wsq;
            end
            npq_pkg::MODE_POW:
            begin
                f_next.x = {26'b0, p_pow};
                f_next.y = {32'b0, cfg.w};
            end
            default:
            begin
                f_next.x = {34'b0, p_uni};
                f_next.y = {32'b0, cfg.w};
            end
        endcase
    end

    genvar i;
    for (i = 0; i < 8; i++) begin : g_srch
        localparam int S = 7 - i;
        srch_t       src;
        logic [73:0] yext;
        logic [73:0] stp;
        logic [73:0] t;
        logic [7:0]  cand;
        logic [51:0] prod;
        logic        ok;
        logic        is_log;
        logic        is_pow;
        if (i == 0) begin : g_first
            assign src = f_reg;
        end
        else begin : g_rest
            assign src = srch_reg[i-1];
        end
        assign is_log = cfg.mode == npq_pkg::MODE_LOG;
        assign is_pow = cfg.mode == npq_pkg::MODE_POW;
        assign yext = {10'b0, src.y};
        assign stp  = yext << S;
        assign t    = is_pow ? (src.p + (src.q << (S + 1)) + (yext << (2 * S)))
                             : (src.p + stp);
        assign cand = src.k | (8'd1 << S);
        assign prod = {20'b0, src.y[31:0]} * {32'b0, npq_pkg::LOG_TAB[cand]};
        assign ok   = is_log ? ({22'b0, prod} <= src.x) : (t <= src.x);
        always_comb
        begin
            srch_next[i] = src;
            if (ok)
            begin
                srch_next[i].k = cand;
                if (!is_log)
                begin
                    srch_next[i].p = t;
                end
                if (is_pow)
                begin
                    srch_next[i].q = src.q + stp;
                end
            end
        end
    end

    always_comb
    begin
        case (srch_reg[7].kind)
            npq_pkg::KIND_TOP:       level_next = cfg.n;
            npq_pkg::KIND_ZERO:      level_next = '0;
            npq_pkg::KIND_RANGE_ERR: level_next = '0;
            default:
            begin
                if (srch_reg[7].zden)
                begin
                    level_next = '0;
                end
                else
                begin
                    level_next = (srch_reg[7].k > cfg.n) ? cfg.n : srch_reg[7].k;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                lg_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < 8; k++) begin
                srch_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg     <= pop_valid;
            b_valid_reg     <= a_valid_reg;
            lg_valid_reg[0] <= b_valid_reg;
            for (int k = 1; k < 16; k++) begin
                lg_valid_reg[k] <= lg_valid_reg[k-1];
            end
            f_valid_reg       <= lg_valid_reg[15];
            srch_valid_reg[0] <= f_valid_reg;
            for (int k = 1; k < 8; k++) begin
                srch_valid_reg[k] <= srch_valid_reg[k-1];
            end
            out_valid_reg <= srch_valid_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg <= pop_item.kind;
            a_d_reg    <= pop_item.d;
            a_v_reg    <= a_v_next;
            a_e_reg    <= npq_pkg::lead_one(a_v_next);
            b_reg      <= b_next;
            for (int k = 0; k < 16; k++) begin
                lg_reg[k] <= lg_next[k];
            end
            f_reg <= f_next;
            for (int k = 0; k < 8; k++) begin
                srch_reg[k] <= srch_next[k];
            end
            out_level_reg <= level_next;
            out_rerr_reg  <= srch_reg[7].kind == npq_pkg::KIND_RANGE_ERR;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_rerr  = out_rerr_reg;

endmodule

`default_nettype wire

### design/nonlinear_posterize_quantizer_core.sv
// ----------------------------------------------------------------------------
// nonlinear_posterize_quantizer_core
// Maps signed Q23.8 pixels onto posterization levels 0..N along one of five
// curves (uniform, log, exp, sqrt, pow) between a configured minimum and maximum.
// ----------------------------------------------------------------------------
// Usage. Pixels arrive as words on the s_axis channel and one result word per
// pixel leaves on m_axis, in order. The cfg channel writes the level count,
// the curve, the range minimum and the range maximum by index 0 to 3; writes
// are expected only while no pixel is in flight.
// Throughput is one word per clock while no constant rebuild runs and the
// receiver keeps m_axis_tready high. A pixel passes the classifying front
// end, the queue and the offset and top-bit stage, then 27 further stages
// (mantissa normalisation, a 16-stage Q16 logarithm, one stage that forms the
// operands, eight stages that settle one level bit each, and the output
// register). The logarithm and the bitwise level search make up most of these.
// After reset and after every configuration write the block rebuilds its
// derived range constants with a serial logarithm; s_axis_tready is low
// while this runs. When m_axis_tready is low and a result is waiting, the
// whole back pipeline holds; the front end keeps taking pixels until the
// four-word queue and the front register are full, then drops s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nonlinear_posterize_quantizer_core_defines.svh"

module nonlinear_posterize_quantizer_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Pixel stream in.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] pixel
    // Level stream out.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] level
    output logic              m_axis_tuser,   // [0] range_error
    // Configuration writes.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    npq_pkg::cfg_t  cfg;
    logic           push_valid;
    logic           push_ready;
    npq_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    npq_pkg::item_t pop_item;

    // Register file and the constants that follow from it.
    npq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Front end: subtracts the minimum and sorts each pixel into below range,
    // above range, range error or a curve evaluation.
    npq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_pixel   (s_axis_tdata),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue, so that a stalled receiver does not stop intake at once.
    npq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back end: the curve pipeline ending in the output register.
    npq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .cfg       (cfg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_level (m_axis_tdata),
        .out_rerr  (m_axis_tuser)
    );

    // A write starts the rebuild of the range constants, so intake must stop.
    `NPQ_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_valid && cfg_ready, !s_axis_tready, "pixel intake open during constant rebuild")
    // No pixel may be taken while the derived constants are stale.
    `NPQ_ASSERT_SAME(a_no_accept_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !cfg.busy, "pixel accepted while constants rebuild")
    // A range error always comes with level zero.
    `NPQ_ASSERT_SAME(a_err_level_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'd0, "range error with a non-zero level")

endmodule

`default_nettype wire

### bench/nonlinear_posterize_quantizer_core_tb.sv
// ----------------------------------------------------------------------------
// Posterization quantizer testbench
// Streams pixels through the quantizer under several range, level-count and
// curve settings. Every result word is checked against a behavioural
// predictor, or against a typed value for the obvious directed cases.
// ----------------------------------------------------------------------------
`default_nettype none

module nonlinear_posterize_quantizer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [7:0] level;
        logic       rerr;
    } level_word_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        bit          typed;
        logic [7:0]  level;
        logic        rerr;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // The predictor's own copy of the registers.
    logic [7:0]  mdl_count;
    logic [2:0]  mdl_mode;
    logic [31:0] mdl_low;
    logic [31:0] mdl_high;

    level_word_t pending_levels[$];
    int          mismatches = 0;
    int          sender_idle_pct = 0;
    int          receiver_idle_pct = 0;
    bit          hold_request = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    nonlinear_posterize_quantizer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Base-2 logarithm in Q16 by repeated squaring of the normalised mantissa.
    function automatic logic [63:0] q16_log2(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        frac = '0;
        if (v == 0)
        begin
            return '0;
        end
        while (e < 63 && (v >> (e + 1)) != 0)
        begin
            e++;
        end
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac[15 - i] = 1'b1;
            end
        end
        return (64'(e) << 16) | frac;
    endfunction

    // Level strictly inside the range, 0 < d < w.
    function automatic logic [63:0] curve_level(input logic [63:0] d, input logic [63:0] w,
                                                input logic [63:0] n, input logic [2:0] mode);
        logic [63:0] lo_k, hi_k, mid, ln, a, b, r, qa, ra, x, y;
        case (mode)
            npq_pkg::MODE_LOG:
            begin
                ln = q16_log2(n + 1);
                lo_k = 0;
                hi_k = n;
                while (lo_k < hi_k)
                begin
                    mid = (lo_k + hi_k + 1) >> 1;
                    if (d * ln >= w * q16_log2(mid + 1)) lo_k = mid;
                    else hi_k = mid - 1;
                end
                return lo_k;
            end
            npq_pkg::MODE_EXP:
            begin
                a = q16_log2(d + (64'd1 << npq_pkg::FRAC_BITS))
                    - (64'(npq_pkg::FRAC_BITS) << 16);
                b = q16_log2(w + (64'd1 << npq_pkg::FRAC_BITS))
                    - (64'(npq_pkg::FRAC_BITS) << 16);
                if (b == 0) return 0;
                r = (n * a) / b;
                return (r > n) ? n : r;
            end
            npq_pkg::MODE_SQRT:
            begin
                qa = (n * d) / w;
                ra = (n * d) % w;
                x = qa * d + (ra * d) / w;
                r = x / w;
                return (r > n) ? n : r;
            end
            npq_pkg::MODE_POW:
            begin
                y = (n * n * d) / w;
                r = 0;
                for (int bit_w = 128; bit_w != 0; bit_w >>= 1)
                begin
                    if ((r + bit_w) * (r + bit_w) <= y) r = r + bit_w;
                end
                return (r > n) ? n : r;
            end
            default: return (n * d) / w;
        endcase
    endfunction

    function automatic level_word_t predict_level(input logic [31:0] px);
        level_word_t      res;
        longint signed    lo, hi, sd, sw;
        logic [63:0]      n;
        lo = longint'($signed(mdl_low));
        hi = longint'($signed(mdl_high));
        n = 64'(mdl_count);
        res.rerr = 1'b0;
        if (hi <= lo)
        begin
            res.level = '0;
            res.rerr = 1'b1;
            return res;
        end
        sd = longint'($signed(px)) - lo;
        sw = hi - lo;
        if (sd <= 0) res.level = '0;
        else if (sd >= sw) res.level = n[7:0];
        else res.level = 8'(curve_level(64'(sd), 64'(sw), n, mdl_mode));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 20)
        begin
            $display("error: %s got %0d, wanted %0d", what, got, want);
        end
        mismatches++;
    endtask

    // Offer one pixel; the word is taken at the first edge with tready high.
    task automatic send_pixel(input logic [31:0] px, input bit typed,
                              input level_word_t typed_word);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge clk); while (!s_axis_tready);
        pending_levels.push_back(typed ? typed_word : predict_level(px));
    endtask

    // Register writes happen only once the pipeline has drained.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            npq_pkg::REG_LEVEL_COUNT: mdl_count = val[7:0];
            npq_pkg::REG_CURVE_MODE:  mdl_mode = val[2:0];
            npq_pkg::REG_RANGE_LOW:   mdl_low = val;
            default:                  mdl_high = val;
        endcase
    endtask

    // Receiver: random stalls, plus one long hold-off on request so that the
    // queue fills and the block has to drop s_axis_tready.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Every result word is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        level_word_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch("unexpected result word, level", 32'(m_axis_tdata), 32'd0);
            end
            else
            begin
                want = pending_levels.pop_front();
                if (m_axis_tdata !== want.level)
                    report_mismatch("level", 32'(m_axis_tdata), 32'(want.level));
                if (m_axis_tuser !== want.rerr)
                    report_mismatch("range_error", 32'(m_axis_tuser), 32'(want.rerr));
            end
        end
    end

    // Watchdog: too long without any word moving on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nonlinear_posterize_quantizer_core: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        stim_row_t     directed_rows [28];
        level_word_t   typed_word;
        longint signed lo, span, px;
        logic [31:0]   hi_word, px_word;
        int            cnt_pick;

        // Directed part. Typed results are the ones obvious from the defaults
        // (N = 16 over 0..255.0), the extremes and the range error.
        directed_rows = '{
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd0,                   1, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd65280,               1, 8'd16,  1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'h7FFF_FFFF,           1, 8'd16,  1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'h8000_0000,           1, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd32640,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_CURVE_MODE,  32'(npq_pkg::MODE_LOG),  0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd20000,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_CURVE_MODE,  32'(npq_pkg::MODE_EXP),  0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd20000,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_CURVE_MODE,  32'(npq_pkg::MODE_SQRT), 0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd20000,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_CURVE_MODE,  32'(npq_pkg::MODE_POW),  0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd20000,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_CURVE_MODE,  32'd7,                   0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd20000,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_LEVEL_COUNT, 32'd255,                 0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd65280,               1, 8'd255, 1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd100,                 0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_LEVEL_COUNT, 32'd0,                   0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd30000,               1, 8'd0,   1'b0},
            '{1, npq_pkg::REG_LEVEL_COUNT, 32'd1,                   0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd65279,               0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_RANGE_LOW,   32'h8000_0000,           0, 8'd0,   1'b0},
            '{1, npq_pkg::REG_RANGE_HIGH,  32'h7FFF_FFFF,           0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd0,                   0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'h7FFF_FFFF,           1, 8'd1,   1'b0},
            '{1, npq_pkg::REG_RANGE_HIGH,  32'h8000_0000,           0, 8'd0,   1'b0},
            '{0, npq_pkg::REG_LEVEL_COUNT, 32'd5,                   1, 8'd0,   1'b1}
        };

        mdl_count = npq_pkg::LEVEL_COUNT_RST;
        mdl_mode = npq_pkg::MODE_UNIFORM;
        mdl_low = '0;
        mdl_high = npq_pkg::RANGE_HIGH_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender busy, receiver often stalled, first; the long hold-off is
        // asked for early so that the queue fills behind it.
        sender_idle_pct = 26;
        receiver_idle_pct = 54;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                write_register(directed_rows[i].idx, directed_rows[i].val);
            end
            else
            begin
                typed_word.level = directed_rows[i].level;
                typed_word.rerr = directed_rows[i].rerr;
                send_pixel(directed_rows[i].val, directed_rows[i].typed, typed_word);
            end
        end

        // Random part: twelve settings of about eighty pixels each.
        for (int batch = 0; batch < 12; batch++)
        begin
            if (batch == 4)
            begin
                sender_idle_pct = 54;
                receiver_idle_pct = 26;
            end
            else if (batch == 8)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end

            cnt_pick = $urandom_range(7);
            write_register(npq_pkg::REG_LEVEL_COUNT,
                           (cnt_pick == 0) ? 32'd255 : (cnt_pick == 1) ? 32'd2 :
                           (cnt_pick == 2) ? 32'($urandom_range(1)) : $urandom);
            write_register(npq_pkg::REG_CURVE_MODE,
                           (batch < 10) ? 32'(batch % 5) : $urandom);

            // Mostly a valid range of random width; now and then a reversed one.
            lo = longint'($signed($urandom));
            span = longint'($urandom >> $urandom_range(31)) + 1;
            if ($urandom_range(9) == 0) span = -longint'($urandom_range(1000));
            if (lo + span > 64'sd2147483647) span = 64'sd2147483647 - lo;
            if (lo + span < -64'sd2147483648) span = -64'sd2147483648 - lo;
            hi_word = 32'(lo + span);
            write_register(npq_pkg::REG_RANGE_LOW, 32'(lo));
            write_register(npq_pkg::REG_RANGE_HIGH, hi_word);

            if (batch == 0) hold_request = 1'b1;

            for (int k = 0; k < 80; k++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    px_word = $urandom;
                end
                else
                begin
                    px = lo + ((longint'($urandom) * ((span > 0) ? span : 1)) >>> 32)
                         + longint'($urandom_range(4)) - 2;
                    px_word = 32'(px);
                end
                send_pixel(px_word, 1'b0, typed_word);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("nonlinear_posterize_quantizer_core: match");
        end
        else
        begin
            $display("nonlinear_posterize_quantizer_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### nonlinear_posterize_quantizer_core.f
+incdir+design
design/npq_pkg.sv
design/npq_cfg.sv
design/npq_front.sv
design/npq_fifo.sv
design/npq_back.sv
design/nonlinear_posterize_quantizer_core.sv
bench/nonlinear_posterize_quantizer_core_tb.sv
